/* rtl/epm_pkg.sv */
// ----------------------------------------------------------------------------
// epm_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int CordicMaxStages     = 24;

  localparam logic signed [16:0] AngPi     = 17'sd25736;
  localparam logic signed [16:0] AngHalfPi = 17'sd12868;
  localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [15:0] OneQ14    = 16'sd16384;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [31:0] shift_t;
  typedef logic signed [15:0] rot_t;

  // CORDIC working word: Q2.30 plus growth margin
  typedef logic signed [33:0] cw_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } cord_lane_t;

  typedef struct packed {
    cord_lane_t [2:0] lane;
    shift_t     [2:0] t;
  } cord_word_t;

  typedef struct packed {
    rot_t [2:0] c;
    rot_t [2:0] s;
    shift_t [2:0] t;
  } sc_word_t;

  typedef struct packed {
    rot_t   r00, r01, r02, r10, r11, r12, r20, r21, r22;
    shift_t out_x, out_y, out_z;
  } res_word_t;

  typedef struct packed {
    ang_t   angle_x, angle_y, angle_z;
    shift_t shift_x, shift_y, shift_z;
  } pose_word_t;

  function automatic cw_t atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return cw_t'({2'b00, v});
  endfunction

  // round half up by 16 from Q2.30 to Q1.14, clamp to +-1.0
  function automatic rot_t q30_to_q14(input cw_t v);
    logic signed [33:0] r;
    logic signed [17:0] q;
    r = v + 34'sd32768;
    q = 18'(r >>> 16);
    if (q > 18'sd16384) return OneQ14;
    if (q < -18'sd16384) return -OneQ14;
    return rot_t'(q);
  endfunction

  // round half up by 28, clamp to +-1.0
  function automatic rot_t q42_to_q14(input logic signed [43:0] v);
    logic signed [43:0] r;
    logic signed [15:0] q;
    r = v + 44'sh000_0800_0000;
    q = 16'(r >>> 28);
    if (q > 16'sd16384) return OneQ14;
    if (q < -16'sd16384) return -OneQ14;
    return q;
  endfunction

  // round half up by 14, saturate to 32 bits
  function automatic shift_t q30_to_q16(input logic signed [50:0] v);
    logic signed [50:0] r;
    logic signed [36:0] q;
    r = v + 51'sd8192;
    q = 37'(r >>> 14);
    if (q > 37'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (q < -37'sh080000000) return 32'sh80000000;
    return shift_t'(q);
  endfunction

endpackage

/* rtl/epm_if.sv */
// ----------------------------------------------------------------------------
// epm_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface epm_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/epm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// epm_cordic_cell
// One CORDIC micro-rotation for three angle lanes; passes the word on.
// ----------------------------------------------------------------------------
module epm_cordic_cell
  import epm_pkg::*;
#(
  parameter int Stage = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  cord_word_t in_word,
  output logic       out_valid,
  output cord_word_t out_word
);

  cord_word_t word_next;
  localparam cw_t Atan = atan_q30(Stage);

  always_comb begin
    word_next = in_word;
    for (int l = 0; l < 3; l++) begin
      if (!in_word.lane[l].z[33]) begin
        word_next.lane[l].x = in_word.lane[l].x - (in_word.lane[l].y >>> Stage);
        word_next.lane[l].y = in_word.lane[l].y + (in_word.lane[l].x >>> Stage);
        word_next.lane[l].z = in_word.lane[l].z - Atan;
      end else begin
        word_next.lane[l].x = in_word.lane[l].x + (in_word.lane[l].y >>> Stage);
        word_next.lane[l].y = in_word.lane[l].y - (in_word.lane[l].x >>> Stage);
        word_next.lane[l].z = in_word.lane[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

/* rtl/epm_matrix.sv */
// ----------------------------------------------------------------------------
// epm_matrix
// Builds rotation entries and the inverse translation from sines/cosines.
// Five register stages.
// ----------------------------------------------------------------------------
module epm_matrix
  import epm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  sc_word_t  in_word,
  output logic      out_valid,
  output res_word_t out_word
);

  typedef logic signed [29:0] p28_t;
  typedef logic signed [43:0] p42_t;

  logic [4:0] vld;

  // stage 1: pair products (Q28)
  p28_t cycz, sysx, cysz, cxsz, cxcz, sycz, cysx, sysz;
  p28_t sycx, cycx, sxs;
  rot_t sz1, cz1;
  shift_t [2:0] t1;
  // stage 2: entries at 2^-42
  p42_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
  shift_t [2:0] t2;
  // stage 3: rounded entries
  rot_t [2:0][2:0] r3;
  shift_t [2:0] t3;
  // stage 4: products
  logic signed [47:0] pr [3][3];
  rot_t [2:0][2:0] r4;

  rot_t cx, sx, cy, sy, cz, sz;
  assign cx = in_word.c[0];
  assign sx = in_word.s[0];
  assign cy = in_word.c[1];
  assign sy = in_word.s[1];
  assign cz = in_word.c[2];
  assign sz = in_word.s[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
    if (en) begin
      cycz <= 30'(cy * cz);
      sysx <= 30'(sy * sx);
      cysz <= 30'(cy * sz);
      cxsz <= 30'(cx * sz);
      cxcz <= 30'(cx * cz);
      sycz <= 30'(sy * cz);
      cysx <= 30'(cy * sx);
      sysz <= 30'(sy * sz);
      sycx <= 30'(sy * cx);
      cycx <= 30'(cy * cx);
      sxs  <= 30'(sx * OneQ14);
      sz1  <= sz;
      cz1  <= cz;
      t1   <= in_word.t;

      e00 <= (44'(cycz) <<< 14) + 44'(sysx * sz1);
      e01 <= -(44'(cysz) <<< 14) + 44'(sysx * cz1);
      e02 <= 44'(sycx) <<< 14;
      e10 <= 44'(cxsz) <<< 14;
      e11 <= 44'(cxcz) <<< 14;
      e12 <= -(44'(sxs) <<< 14);
      e20 <= -(44'(sycz) <<< 14) + 44'(cysx * sz1);
      e21 <= (44'(sysz) <<< 14) + 44'(cysx * cz1);
      e22 <= 44'(cycx) <<< 14;
      t2  <= t1;

      r3[0][0] <= q42_to_q14(e00);
      r3[0][1] <= q42_to_q14(e01);
      r3[0][2] <= q42_to_q14(e02);
      r3[1][0] <= q42_to_q14(e10);
      r3[1][1] <= q42_to_q14(e11);
      r3[1][2] <= q42_to_q14(e12);
      r3[2][0] <= q42_to_q14(e20);
      r3[2][1] <= q42_to_q14(e21);
      r3[2][2] <= q42_to_q14(e22);
      t3 <= t2;

      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr[k][j] <= 48'(r3[k][j] * t3[j]);
        end
      end
      r4 <= r3;

      out_word.r00   <= r4[0][0];
      out_word.r01   <= -r4[0][2];
      out_word.r02   <= -r4[0][1];
      out_word.r10   <= -r4[2][0];
      out_word.r11   <= r4[2][2];
      out_word.r12   <= r4[2][1];
      out_word.r20   <= -r4[1][0];
      out_word.r21   <= r4[1][2];
      out_word.r22   <= r4[1][1];
      out_word.out_x <= q30_to_q16(51'(pr[0][0]) + 51'(pr[0][1]) + 51'(pr[0][2]));
      out_word.out_y <= q30_to_q16(-(51'(pr[2][0]) + 51'(pr[2][1]) + 51'(pr[2][2])));
      out_word.out_z <= q30_to_q16(-(51'(pr[1][0]) + 51'(pr[1][1]) + 51'(pr[1][2])));
    end
  end

  assign out_valid = vld[4];

endmodule

/* rtl/euler_pose_to_matrix.sv */
// ----------------------------------------------------------------------------
// euler_pose_to_matrix
// Pose to rotation matrix and inverse translation via a chain of CORDIC cells.
// Registers in order: front stage, CORDIC cells, sine/cosine register, matrix.
// The chain advances whenever the output register is empty or being taken;
// it then takes one word per cycle, so the word rate is set by the consumer.
// Synchronous reset clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_pose_to_matrix
  import epm_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input logic clk,
  input logic rst,
  epm_if.sink   pose,
  epm_if.source result
);

  localparam int NStg = (CORDIC_STAGES < CordicMaxStages) ? CORDIC_STAGES
                                                         : CordicMaxStages;

  logic en;
  assign en = !result.valid || result.ready;
  assign pose.ready = en;

  // front stage: angle reduction
  logic       v0;
  cord_word_t w0;
  pose_word_t p;
  ang_t       angs [3];
  assign p = pose.data;
  assign angs[0] = p.angle_x;
  assign angs[1] = p.angle_y;
  assign angs[2] = p.angle_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pose.valid;
    end
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [16:0] th;
        logic               fl;
        th = -17'(angs[l]);
        fl = 1'b0;
        if (th > AngHalfPi) begin
          th = th - AngPi;
          fl = 1'b1;
        end else if (th < -AngHalfPi) begin
          th = th + AngPi;
          fl = 1'b1;
        end
        w0.lane[l].flip <= fl;
        w0.lane[l].x <= CordicGain;
        w0.lane[l].y <= '0;
        w0.lane[l].z <= cw_t'(th) <<< 17;
      end
      w0.t[0] <= p.shift_x;
      w0.t[1] <= p.shift_y;
      w0.t[2] <= p.shift_z;
    end
  end

  logic       cv [NStg+1];
  cord_word_t cw [NStg+1];
  assign cv[0] = v0;
  assign cw[0] = w0;

  for (genvar g = 0; g < NStg; g++) begin : g_cell
    epm_cordic_cell #(.Stage(g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[g]), .in_word(cw[g]),
      .out_valid(cv[g+1]), .out_word(cw[g+1])
    );
  end

  // sine/cosine rounding register
  logic     sv;
  sc_word_t sw;
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (en) begin
      sv <= cv[NStg];
    end
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rot_t c, s;
        c = q30_to_q14(cw[NStg].lane[l].x);
        s = q30_to_q14(cw[NStg].lane[l].y);
        sw.c[l] <= cw[NStg].lane[l].flip ? -c : c;
        sw.s[l] <= cw[NStg].lane[l].flip ? -s : s;
      end
      sw.t <= cw[NStg].t;
    end
  end

  epm_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sv), .in_word(sw),
    .out_valid(result.valid), .out_word(result.data)
  );

  a_hold : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.data))
    else $error("result changed while stalled");
  a_ready : assert property (@(posedge clk) disable iff (rst)
    pose.ready == (!result.valid || result.ready))
    else $error("ready not tied to output slot");
  a_r22 : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.r22 <= OneQ14 && result.data.r22 >= -OneQ14))
    else $error("rotation entry out of range");

endmodule
